// File: hdl/caccu_pkg.sv
// ----------------------------------------------------------------------------
// Credential access check package
// Shared command codes, status codes and transfer types.
// ----------------------------------------------------------------------------
package caccu_pkg;

    localparam logic [3:0] CMD_CHECK        = 4'd0;
    localparam logic [3:0] CMD_SET_UID      = 4'd1;
    localparam logic [3:0] CMD_SET_GID      = 4'd2;
    localparam logic [3:0] CMD_REUID        = 4'd3;
    localparam logic [3:0] CMD_REGID        = 4'd4;
    localparam logic [3:0] CMD_RESUID       = 4'd5;
    localparam logic [3:0] CMD_RESGID       = 4'd6;
    localparam logic [3:0] CMD_FSUID        = 4'd7;
    localparam logic [3:0] CMD_FSGID        = 4'd8;
    localparam logic [3:0] CMD_GROUPS_BEGIN = 4'd9;
    localparam logic [3:0] CMD_GROUP_ENTRY  = 4'd10;
    localparam logic [3:0] CMD_EXEC         = 4'd11;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PERM  = 2'd1;
    localparam logic [1:0] ST_ACCES = 2'd2;
    localparam logic [1:0] ST_INVAL = 2'd3;

    localparam logic [31:0] ID_UNCHANGED = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] id_real;
        logic [31:0] id_effective;
        logic [31:0] id_saved;
        logic [31:0] node_owner;
        logic [31:0] node_group;
        logic [11:0] node_mode;
        logic        node_is_directory;
        logic        node_present;
        logic [2:0]  access_want;
        logic        suppress_setid;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] previous_id;
    } result_item_t;

endpackage

// File: hdl/caccu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module caccu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/credential_access_check_unit.sv
// ----------------------------------------------------------------------------
// Credential access check unit
// Holds one process's user and group credentials and answers access checks
// and set-ID commands, one status per command.
// ----------------------------------------------------------------------------
// Channel   Direction  Type           Handshake
// cmd       in         cmd_item_t     cmd_valid / cmd_stall
// rsp       out        result_item_t  rsp_valid / rsp_stall
//
// A command is registered on transfer and executed before its result is
// presented. A check that scans the group table walks the groups in use and
// ends early on a match; the scan reads one RAM entry per cycle through one
// shared comparator. The unit returns to idle after each result before it
// takes the next command.
// Reset clears all IDs and group counts; the group table is not cleared.
// A stalled result holds; the next command is taken once it is transferred.
// ----------------------------------------------------------------------------
module credential_access_check_unit #(
    parameter int MAX_GROUPS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  caccu_pkg::cmd_item_t          cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output caccu_pkg::result_item_t       rsp
);
    import caccu_pkg::*;

    localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW = $clog2(MAX_GROUPS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    cmd_item_t   item_reg;
    logic [31:0] ru_reg, eu_reg, su_reg, fu_reg;
    logic [31:0] rg_reg, eg_reg, sg_reg, fg_reg;
    logic [CW-1:0] in_use_reg, expected_reg, loaded_reg;
    logic [CW-1:0] idx_reg;
    logic          member_reg;
    logic          scan_hit;
    result_item_t  rsp_reg;

    logic              wr_en;
    logic [AW-1:0]     rd_addr;
    logic [31:0]       rd_data;

    caccu_ram #(.WIDTH(32), .DEPTH(MAX_GROUPS), .AW(AW)) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (loaded_reg[AW-1:0]),
        .wr_data (item_reg.id_real),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);
    assign rsp       = rsp_reg;
    assign rd_addr   = idx_reg[AW-1:0];

    // Read data is registered, so the entry below idx is compared.
    assign scan_hit  = member_reg || (idx_reg != '0 && rd_data == item_reg.node_group);

    function automatic logic any3(input logic [31:0] v, a, b, c);
        any3 = (v == a) || (v == b) || (v == c);
    endfunction

    // Access check result from the selected rwx triple, with the override for filesystem user ID 0.
    function automatic logic [1:0] chk(input cmd_item_t it, input logic [31:0] fu,
                                       input logic mem);
        logic [2:0] allowed;
        allowed = (fu == it.node_owner) ? it.node_mode[8:6]
                : mem ? it.node_mode[5:3] : it.node_mode[2:0];
        if ((allowed & it.access_want) == it.access_want)
            chk = ST_OK;
        else if (fu == 32'd0 && (!it.access_want[0] || it.node_is_directory
                 || (|{it.node_mode[6], it.node_mode[3], it.node_mode[0]})))
            chk = ST_OK;
        else
            chk = ST_ACCES;
    endfunction

    logic [31:0] r_c, e_c, s_c, f_c;
    logic [31:0] r_n, e_n, s_n, f_n;
    logic [1:0]  st_n;
    logic [31:0] prev_n;
    logic        priv;
    logic [31:0] a, b, c;

    always_comb
    begin
        a = item_reg.id_real;
        b = item_reg.id_effective;
        c = item_reg.id_saved;
        priv = (eu_reg == 32'd0);
        if (item_reg.command inside {CMD_SET_GID, CMD_REGID, CMD_RESGID, CMD_FSGID})
        begin
            r_c = rg_reg; e_c = eg_reg; s_c = sg_reg; f_c = fg_reg;
        end
        else
        begin
            r_c = ru_reg; e_c = eu_reg; s_c = su_reg; f_c = fu_reg;
        end
        r_n = r_c; e_n = e_c; s_n = s_c; f_n = f_c;
        st_n = ST_OK;
        prev_n = 32'd0;
        case (item_reg.command)
            CMD_SET_UID, CMD_SET_GID:
            begin
                if (a == ID_UNCHANGED)
                    st_n = ST_INVAL;
                else if (priv)
                begin
                    r_n = a; e_n = a; s_n = a; f_n = a;
                end
                else if (a != r_c && a != s_c)
                    st_n = ST_PERM;
                else
                begin
                    e_n = a; f_n = a;
                end
            end
            CMD_REUID, CMD_REGID:
            begin
                if (!priv && ((a != ID_UNCHANGED && a != r_c && a != e_c)
                    || (b != ID_UNCHANGED && !any3(b, r_c, e_c, s_c))))
                    st_n = ST_PERM;
                else
                begin
                    if (a != ID_UNCHANGED) r_n = a;
                    if (b != ID_UNCHANGED) e_n = b;
                    if (a != ID_UNCHANGED || (b != ID_UNCHANGED && b != r_c))
                        s_n = e_n;
                    f_n = e_n;
                end
            end
            CMD_RESUID, CMD_RESGID:
            begin
                if (!priv && ((a != ID_UNCHANGED && !any3(a, r_c, e_c, s_c))
                    || (b != ID_UNCHANGED && !any3(b, r_c, e_c, s_c))
                    || (c != ID_UNCHANGED && !any3(c, r_c, e_c, s_c))))
                    st_n = ST_PERM;
                else
                begin
                    if (a != ID_UNCHANGED) r_n = a;
                    if (b != ID_UNCHANGED) e_n = b;
                    if (c != ID_UNCHANGED) s_n = c;
                    f_n = e_n;
                end
            end
            CMD_FSUID, CMD_FSGID:
            begin
                prev_n = f_c;
                if (priv || any3(a, r_c, e_c, s_c))
                    f_n = a;
            end
            CMD_CHECK, CMD_EXEC:
            begin
            end
            CMD_GROUPS_BEGIN:
            begin
                if (a > 32'(MAX_GROUPS))
                    st_n = ST_INVAL;
                else if (!priv)
                    st_n = ST_PERM;
            end
            CMD_GROUP_ENTRY:
            begin
                if (loaded_reg >= expected_reg)
                    st_n = ST_INVAL;
            end
            default:
            begin
                st_n = ST_INVAL;
            end
        endcase
    end

    assign wr_en = (state_reg == S_EXEC) && (item_reg.command == CMD_GROUP_ENTRY)
                   && (loaded_reg < expected_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (cmd_valid) state_next = S_EXEC;
            S_EXEC:
            begin
                if (item_reg.command == CMD_CHECK && item_reg.access_want != 3'd0
                    && fu_reg != item_reg.node_owner && fg_reg != item_reg.node_group
                    && in_use_reg != '0)
                    state_next = S_SCAN;
                else
                    state_next = S_OUT;
            end
            S_SCAN:
            begin
                if (idx_reg == in_use_reg || scan_hit)
                    state_next = S_OUT;
            end
            S_OUT: if (!rsp_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
            item_reg <= cmd;
        if (state_reg == S_EXEC)
        begin
            rsp_reg.status      <= (item_reg.command == CMD_CHECK)
                ? ((item_reg.access_want == 3'd0) ? ST_OK
                   : chk(item_reg, fu_reg, fg_reg == item_reg.node_group))
                : st_n;
            rsp_reg.previous_id <= prev_n;
        end
        else if (state_reg == S_SCAN && state_next == S_OUT)
        begin
            rsp_reg.status <= chk(item_reg, fu_reg, scan_hit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ru_reg <= '0; eu_reg <= '0; su_reg <= '0; fu_reg <= '0;
            rg_reg <= '0; eg_reg <= '0; sg_reg <= '0; fg_reg <= '0;
            in_use_reg   <= '0;
            expected_reg <= '0;
            loaded_reg   <= '0;
            idx_reg      <= '0;
            member_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                idx_reg    <= '0;
                member_reg <= 1'b0;
                case (item_reg.command)
                    CMD_SET_UID, CMD_REUID, CMD_RESUID, CMD_FSUID:
                    begin
                        ru_reg <= r_n; eu_reg <= e_n; su_reg <= s_n; fu_reg <= f_n;
                    end
                    CMD_SET_GID, CMD_REGID, CMD_RESGID, CMD_FSGID:
                    begin
                        rg_reg <= r_n; eg_reg <= e_n; sg_reg <= s_n; fg_reg <= f_n;
                    end
                    CMD_GROUPS_BEGIN:
                    begin
                        if (st_n == ST_OK)
                        begin
                            expected_reg <= item_reg.id_real[CW-1:0];
                            loaded_reg   <= '0;
                            in_use_reg   <= '0;
                        end
                    end
                    CMD_GROUP_ENTRY:
                    begin
                        if (wr_en)
                        begin
                            loaded_reg <= loaded_reg + 1'b1;
                            if (loaded_reg + 1'b1 == expected_reg)
                                in_use_reg <= expected_reg;
                        end
                    end
                    CMD_EXEC:
                    begin
                        if (item_reg.node_present && !item_reg.suppress_setid
                            && item_reg.node_mode[11])
                        begin
                            eu_reg <= item_reg.node_owner;
                            su_reg <= item_reg.node_owner;
                            fu_reg <= item_reg.node_owner;
                        end
                        else
                        begin
                            su_reg <= eu_reg;
                            fu_reg <= eu_reg;
                        end
                        if (item_reg.node_present && !item_reg.suppress_setid
                            && item_reg.node_mode[10] && item_reg.node_mode[3])
                        begin
                            eg_reg <= item_reg.node_group;
                            sg_reg <= item_reg.node_group;
                            fg_reg <= item_reg.node_group;
                        end
                        else
                        begin
                            sg_reg <= eg_reg;
                            fg_reg <= eg_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (state_reg == S_SCAN)
            begin
                // Read data is registered, so it belongs to the entry below idx.
                if (idx_reg != '0 && rd_data == item_reg.node_group)
                    member_reg <= 1'b1;
                if (idx_reg != in_use_reg)
                    idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    ap_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_use_reg <= expected_reg && loaded_reg <= expected_reg)
        else $error("group counts out of order");
    ap_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> idx_reg <= in_use_reg)
        else $error("scan index beyond groups in use");
    ap_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cmd_stall)
        else $error("command taken while result pending");
    ap_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall |=> !rsp_valid)
        else $error("result repeated");

endmodule

// File: verif/tb_credential_access_check_unit.sv
// ----------------------------------------------------------------------------
// Credential access check unit testbench
// Drives directed and random command transfers with random idle cycles on
// both channels, predicts every status and previous ID from a behavioral
// copy of the credential state, and compares each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_credential_access_check_unit;

    import caccu_pkg::*;

    localparam int NUM_GROUPS = 32;
    localparam int RANDOM_ITEMS = 1400;
    localparam longint CYCLE_LIMIT = 2000000;

    class result_scoreboard;
        logic [31:0] ruid, euid, suid, fsuid;
        logic [31:0] rgid, egid, sgid, fsgid;
        logic [31:0] group_table [NUM_GROUPS];
        int unsigned groups_in_use, groups_expected, groups_loaded;
        result_item_t pending [$];
        int mismatches;

        function new();
            ruid = 0; euid = 0; suid = 0; fsuid = 0;
            rgid = 0; egid = 0; sgid = 0; fsgid = 0;
            groups_in_use = 0; groups_expected = 0; groups_loaded = 0;
            mismatches = 0;
            foreach (group_table[k]) group_table[k] = 0;
        endfunction

        function bit is_member(logic [31:0] gid);
            if (fsgid == gid) return 1;
            for (int k = 0; k < groups_in_use; k++)
                if (group_table[k] == gid) return 1;
            return 0;
        endfunction

        function logic [1:0] check_access(cmd_item_t c);
            logic [2:0] allowed;
            if (c.access_want == 0) return ST_OK;
            if (fsuid == c.node_owner) allowed = c.node_mode[8:6];
            else if (is_member(c.node_group)) allowed = c.node_mode[5:3];
            else allowed = c.node_mode[2:0];
            if ((allowed & c.access_want) == c.access_want) return ST_OK;
            if (fsuid == 0) begin
                if (!c.access_want[0] || c.node_is_directory) return ST_OK;
                if (c.node_mode[6] || c.node_mode[3] || c.node_mode[0]) return ST_OK;
            end
            return ST_ACCES;
        endfunction

        function logic [1:0] set_single(logic [31:0] id, ref logic [31:0] r, e, s, f);
            if (id == ID_UNCHANGED) return ST_INVAL;
            if (euid == 0) begin
                r = id; e = id; s = id; f = id;
                return ST_OK;
            end
            if (id != r && id != s) return ST_PERM;
            e = id; f = id;
            return ST_OK;
        endfunction

        function logic [1:0] set_re(logic [31:0] nr, ne, ref logic [31:0] r, e, s, f);
            logic [31:0] old_r;
            old_r = r;
            if (euid != 0) begin
                if (nr != ID_UNCHANGED && nr != r && nr != e) return ST_PERM;
                if (ne != ID_UNCHANGED && ne != r && ne != e && ne != s) return ST_PERM;
            end
            if (nr != ID_UNCHANGED) r = nr;
            if (ne != ID_UNCHANGED) e = ne;
            if (nr != ID_UNCHANGED || (ne != ID_UNCHANGED && ne != old_r)) s = e;
            f = e;
            return ST_OK;
        endfunction

        function logic [1:0] set_res(logic [31:0] nr, ne, ns, ref logic [31:0] r, e, s, f);
            if (euid != 0) begin
                if (nr != ID_UNCHANGED && nr != r && nr != e && nr != s) return ST_PERM;
                if (ne != ID_UNCHANGED && ne != r && ne != e && ne != s) return ST_PERM;
                if (ns != ID_UNCHANGED && ns != r && ns != e && ns != s) return ST_PERM;
            end
            if (nr != ID_UNCHANGED) r = nr;
            if (ne != ID_UNCHANGED) e = ne;
            if (ns != ID_UNCHANGED) s = ns;
            f = e;
            return ST_OK;
        endfunction

        function logic [31:0] set_fs(logic [31:0] id, logic [31:0] r, e, s,
                                     ref logic [31:0] f);
            logic [31:0] prev;
            prev = f;
            if (euid == 0 || id == r || id == e || id == s || id == f) f = id;
            return prev;
        endfunction

        function void note_command(cmd_item_t c);
            result_item_t res;
            res.status = ST_OK;
            res.previous_id = 0;
            case (c.command)
                CMD_CHECK:   res.status = check_access(c);
                CMD_SET_UID: res.status = set_single(c.id_real, ruid, euid, suid, fsuid);
                CMD_SET_GID: res.status = set_single(c.id_real, rgid, egid, sgid, fsgid);
                CMD_REUID:   res.status = set_re(c.id_real, c.id_effective,
                                                 ruid, euid, suid, fsuid);
                CMD_REGID:   res.status = set_re(c.id_real, c.id_effective,
                                                 rgid, egid, sgid, fsgid);
                CMD_RESUID:  res.status = set_res(c.id_real, c.id_effective, c.id_saved,
                                                  ruid, euid, suid, fsuid);
                CMD_RESGID:  res.status = set_res(c.id_real, c.id_effective, c.id_saved,
                                                  rgid, egid, sgid, fsgid);
                CMD_FSUID:   res.previous_id = set_fs(c.id_real, ruid, euid, suid, fsuid);
                CMD_FSGID:   res.previous_id = set_fs(c.id_real, rgid, egid, sgid, fsgid);
                CMD_GROUPS_BEGIN: begin
                    if (c.id_real > NUM_GROUPS) res.status = ST_INVAL;
                    else if (euid != 0) res.status = ST_PERM;
                    else begin
                        groups_expected = c.id_real;
                        groups_loaded = 0;
                        groups_in_use = 0;
                    end
                end
                CMD_GROUP_ENTRY: begin
                    if (groups_loaded >= groups_expected) res.status = ST_INVAL;
                    else begin
                        group_table[groups_loaded] = c.id_real;
                        groups_loaded++;
                        if (groups_loaded == groups_expected) groups_in_use = groups_expected;
                    end
                end
                CMD_EXEC: begin
                    if (c.node_present && !c.suppress_setid) begin
                        if (c.node_mode[11]) euid = c.node_owner;
                        if (c.node_mode[10] && c.node_mode[3]) egid = c.node_group;
                    end
                    suid = euid; fsuid = euid;
                    sgid = egid; fsgid = egid;
                end
                default: res.status = ST_INVAL;
            endcase
            pending.push_back(res);
        endfunction

        function void check_result(result_item_t got);
            result_item_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d previous_id %h",
                             got.status, got.previous_id);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.previous_id !== want.previous_id) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result mismatch: expected %0d/%h, actual %0d/%h",
                             want.status, want.previous_id, got.status, got.previous_id);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cmd_valid = 0;
    logic cmd_stall;
    cmd_item_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 0;
    result_item_t rsp;

    result_scoreboard board;
    longint cycle_count = 0;
    bit no_idle = 0;

    credential_access_check_unit #(.MAX_GROUPS(NUM_GROUPS)) u_dut (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .cmd(cmd), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_credential_access_check_unit: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall) board.check_result(rsp);
            rsp_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 38);
        end
    end

    function logic [31:0] pick_id();
        case ($urandom_range(5))
            0: return 0;
            1: return ID_UNCHANGED;
            2: return $urandom;
            default: return $urandom_range(4);
        endcase
    endfunction

    task automatic send(cmd_item_t c);
        while (!no_idle && $urandom_range(99) < 38)
        begin
            cmd_valid <= 0;
            @(posedge clk);
        end
        cmd_valid <= 1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        board.note_command(c);
    endtask

    function cmd_item_t random_item();
        cmd_item_t c;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(cmd_item_t)-1:0];
        c.id_real = pick_id();
        c.id_effective = pick_id();
        c.id_saved = pick_id();
        if ($urandom_range(3) != 0) c.node_owner = $urandom_range(4);
        if ($urandom_range(3) != 0) c.node_group = $urandom_range(4);
        case ($urandom_range(19))
            0: c.command = 4'(12 + $urandom_range(3));
            1, 2, 3, 4, 5, 6: c.command = CMD_CHECK;
            7: c.command = CMD_EXEC;
            default: c.command = 4'($urandom_range(CMD_FSGID));
        endcase
        return c;
    endfunction

    task automatic load_groups(int n, bit full_range);
        cmd_item_t c;
        c = '0;
        c.command = CMD_GROUPS_BEGIN;
        c.id_real = n;
        send(c);
        for (int k = 0; k < n; k++)
        begin
            c.command = CMD_GROUP_ENTRY;
            c.id_real = full_range ? $urandom : $urandom_range(6);
            send(c);
        end
    endtask

    initial
    begin
        cmd_item_t c;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        c = '0;
        c.command = CMD_CHECK;
        send(c);
        c.command = CMD_GROUP_ENTRY;
        send(c);
        c.command = CMD_GROUPS_BEGIN;
        c.id_real = NUM_GROUPS + 1;
        send(c);
        load_groups(NUM_GROUPS, 1);
        load_groups(0, 0);
        c = '0;
        c.command = CMD_SET_UID;
        c.id_real = ID_UNCHANGED;
        send(c);
        c.command = CMD_CHECK;
        c.node_owner = 5;
        c.node_group = 5;
        c.node_mode = 12'o644;
        c.access_want = 3'd1;
        send(c);
        c.node_is_directory = 1;
        send(c);
        c.command = CMD_EXEC;
        c.node_present = 1;
        c.node_mode = 12'o6751;
        c.node_owner = 3;
        c.node_group = 4;
        send(c);
        c.command = CMD_SET_UID;
        c.id_real = 9;
        send(c);
        c.command = CMD_GROUPS_BEGIN;
        c.id_real = 1;
        send(c);
        c.command = CMD_FSUID;
        c.id_real = 7;
        send(c);
        c.id_real = 3;
        send(c);
        c.command = 4'd15;
        send(c);
        c.command = CMD_EXEC;
        c.suppress_setid = 1;
        c.node_owner = 0;
        send(c);
        c.suppress_setid = 0;
        c.node_mode = 12'o4000;
        c.node_owner = 0;
        send(c);
        c = '1;
        c.command = CMD_CHECK;
        send(c);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 600 && i < 800);
            if ($urandom_range(29) == 0)
            begin
                c = '0;
                c.command = CMD_EXEC;
                c.node_present = 1;
                c.node_mode = 12'o4000;
                send(c);
                load_groups($urandom_range(5) == 0 ? NUM_GROUPS : $urandom_range(4), 0);
            end
            else
                send(random_item());
        end
        no_idle = 0;
        cmd_valid <= 0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.mismatches == 0)
            $display("tb_credential_access_check_unit: clean");
        else
            $display("tb_credential_access_check_unit: errors");
        $finish;
    end

endmodule
